[hw/rtl/cpf_pkg.sv]
// cpf_pkg: shared constants, types and the CRC step for the packet framer.
// No dependencies; the framer's core, serializer and top level import it.
`default_nettype none

package cpf_pkg;

  // Frame geometry
  localparam int PAYLOAD_BYTES = 21;
  localparam int FRAME_BYTES   = 24;
  localparam int PAD_BYTES     = (FRAME_BYTES >= PAYLOAD_BYTES + 3) ?
                                 (FRAME_BYTES - PAYLOAD_BYTES - 3) : 0;

  // Most frame words one payload word can cause
  localparam int MAX_RESULTS = 5;
  localparam int IDX_W       = 3;
  localparam int CNT_W       = 5;

  // Modbus CRC-16, reflected
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] START_RESET = 8'h5A;

  // Words of one burst, handed from the core to the serializer
  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] words;
    logic [IDX_W-1:0]            last_idx;
    logic                        frame_end;
  } burst_t;

  // One byte through the CRC, eight shift steps unrolled
  function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/cpf_in_if.sv]
// cpf_in_if: valid/ready channel carrying one payload word.
// Stand-alone; used by the framer top level.
`default_nettype none

interface cpf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;

  modport source (output valid, output payload_byte, input ready);
  modport sink   (input valid, input payload_byte, output ready);
endinterface

`default_nettype wire

[hw/rtl/cpf_out_if.sv]
// cpf_out_if: valid/ready channel carrying one frame word and its flags.
// Stand-alone; used by the framer top level.
`default_nettype none

interface cpf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       frame_end;

  modport source (output valid, output out_byte, output run_last, output frame_end,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input frame_end,
                  output ready);
endinterface

`default_nettype wire

[hw/rtl/cpf_core.sv]
// cpf_core: frame state (CRC, payload count, start marker) and burst builder.
// Depends on cpf_pkg.
`default_nettype none

module cpf_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_wr_en,
  input  wire logic [7:0]    cfg_wr_data,
  input  wire logic          accept,
  input  wire logic [7:0]    payload_byte,
  output cpf_pkg::burst_t    burst
);
  import cpf_pkg::*;

  logic [15:0]      crc_accum;
  logic [CNT_W-1:0] byte_count;
  logic [7:0]       start_marker;

  logic [15:0]      crc_next;
  logic [CNT_W-1:0] count_inc;
  logic             complete;
  logic [IDX_W-1:0] n;

  // CRC and frame position after this word
  assign crc_next  = crc_update(crc_accum, payload_byte);
  assign count_inc = byte_count + CNT_W'(1);
  assign complete  = (count_inc >= CNT_W'(PAYLOAD_BYTES)) || (count_inc == '0);

  // Assemble the words this payload word causes
  always_comb begin
    burst.words = '0;
    n = '0;
    if (byte_count == '0) begin
      burst.words[n] = start_marker;
      n = n + IDX_W'(1);
    end
    burst.words[n] = payload_byte;
    n = n + IDX_W'(1);
    if (complete) begin
      burst.words[n] = crc_next[15:8];
      n = n + IDX_W'(1);
      burst.words[n] = crc_next[7:0];
      n = n + IDX_W'(1);
      // zero pad, capped at the burst size
      for (int i = 0; i < MAX_RESULTS; i++) begin
        if (i < PAD_BYTES && n < IDX_W'(MAX_RESULTS)) begin
          n = n + IDX_W'(1);
        end
      end
    end
    burst.last_idx  = n - IDX_W'(1);
    burst.frame_end = complete;
  end

  // Frame state and start marker register
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_accum    <= CRC_INIT;
      byte_count   <= '0;
      start_marker <= START_RESET;
    end else begin
      if (cfg_wr_en) begin
        start_marker <= cfg_wr_data;
      end
      if (accept) begin
        if (complete) begin
          crc_accum  <= CRC_INIT;
          byte_count <= '0;
        end else begin
          crc_accum  <= crc_next;
          byte_count <= count_inc;
        end
      end
    end
  end

  // Payload count never reaches the frame's payload length
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    byte_count < CNT_W'(PAYLOAD_BYTES))
    else $error("payload count out of range");

endmodule

`default_nettype wire

[hw/rtl/cpf_serializer.sv]
// cpf_serializer: holds one burst, sends a word per out_ready cycle.
// Depends on cpf_pkg.
`default_nettype none

module cpf_serializer (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          load,
  input  wire cpf_pkg::burst_t burst,
  output logic               load_ok,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [7:0]         out_byte,
  output logic               run_last,
  output logic               frame_end
);
  import cpf_pkg::*;

  logic [MAX_RESULTS-1:0][7:0] words;
  logic [IDX_W-1:0]            idx;
  logic [IDX_W-1:0]            last_idx;
  logic                        fend;
  logic                        valid;
  logic                        take;
  logic                        at_last;

  assign at_last   = (idx == last_idx);
  assign take      = valid && out_ready;
  // next burst loads as the last word of the current one leaves
  assign load_ok   = !valid || (take && at_last);

  assign out_valid = valid;
  assign out_byte  = words[idx];
  assign run_last  = at_last;
  assign frame_end = fend && at_last;

  // Burst payload
  always_ff @(posedge clk) begin
    if (load) begin
      words    <= burst.words;
      last_idx <= burst.last_idx;
      fend     <= burst.frame_end;
    end
  end

  // Word pointer and valid
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= '0;
    end else if (load) begin
      valid <= 1'b1;
      idx   <= '0;
    end else if (take) begin
      if (at_last) begin
        valid <= 1'b0;
      end else begin
        idx <= idx + IDX_W'(1);
      end
    end
  end

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    valid |-> idx <= last_idx)
    else $error("word pointer past end of burst");

  a_load_start: assert property (@(posedge clk) disable iff (rst)
    load |=> valid && idx == '0)
    else $error("loaded burst does not start at first word");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    take && at_last && !load |=> !valid)
    else $error("burst still valid after its last word");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    valid && !take |-> !load)
    else $error("burst overwritten before it was sent");

endmodule

`default_nettype wire

[hw/rtl/crc16_packet_framer_top.sv]
// crc16_packet_framer_top: wraps payload words into start/payload/CRC/pad frames.
// Depends on cpf_pkg, cpf_in_if, cpf_out_if, cpf_core, cpf_serializer.
//
//   channel   dir   payload                          handshake
//   payload   in    payload_byte[7:0]                valid/ready
//   frame     out   out_byte[7:0] run_last frame_end valid/ready
//   cfg       in    cfg_wr_data[7:0] (start marker)  cfg_wr_en
//
// Each payload word yields 1 to 3 frame words with the 21/24 geometry (never
// more than 5), sent one per cycle from the burst register while the output is
// ready, first word the cycle after the payload word is taken. A payload word is
// taken when the register is empty or its last word leaves, so at a ready output
// one-word bursts sustain one payload word per cycle. Reset (rst, synchronous)
// clears the CRC to 0xFFFF, the count to zero and the start marker to 0x5A. A
// stalled frame word holds until taken, and the payload input stalls behind it.
`default_nettype none

module crc16_packet_framer_top (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data,
  cpf_in_if.sink     payload,
  cpf_out_if.source  frame
);
  import cpf_pkg::*;

  burst_t burst;
  logic   load_ok;
  logic   accept;

  assign payload.ready = load_ok;
  assign accept        = payload.valid && load_ok;

  cpf_core u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .accept       (accept),
    .payload_byte (payload.payload_byte),
    .burst        (burst)
  );

  cpf_serializer u_ser (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .burst     (burst),
    .load_ok   (load_ok),
    .out_valid (frame.valid),
    .out_ready (frame.ready),
    .out_byte  (frame.out_byte),
    .run_last  (frame.run_last),
    .frame_end (frame.frame_end)
  );

endmodule

`default_nettype wire

[tb/cpf_frame_checker.sv]
`timescale 1ns / 1ps
// cpf_frame_checker: watches the payload, frame and start marker ports of the framer,
// predicts every frame word and compares it with what the block sends.
// Depends on cpf_pkg, cpf_in_if and cpf_out_if.

module cpf_frame_checker
  import cpf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  cpf_in_if          payload,
  cpf_out_if         frame,
  output int         fail_count,
  output int         pending_words
);

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       frame_end;
  } frame_word_t;

  frame_word_t      expected_words[$];
  logic [15:0]      crc_run;
  logic [CNT_W-1:0] taken;
  logic [7:0]       marker;
  int               errors = 0;

  // Reflected CRC-16, one bit per pass, LSB first
  function automatic logic [15:0] modbus_crc_byte(input logic [15:0] crc,
                                                  input logic [7:0]  b);
    logic [15:0] c;
    logic        lsb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      lsb = c[0] ^ b[i];
      c   = {1'b0, c[15:1]};
      if (lsb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  // Frame words caused by one payload word, queued in send order
  task automatic predict_frame_words(input logic [7:0] b);
    frame_word_t burst [MAX_RESULTS];
    int          n;
    int          pads;
    n = 0;
    if (taken == 0) begin
      burst[n] = '{data: marker, run_last: 1'b0, frame_end: 1'b0};
      n++;
    end
    burst[n] = '{data: b, run_last: 1'b0, frame_end: 1'b0};
    n++;
    crc_run = modbus_crc_byte(crc_run, b);
    taken   = taken + 1'b1;
    // frame complete: CRC high, CRC low, then pad up to the frame length
    if (taken >= PAYLOAD_BYTES || taken == 0) begin
      burst[n] = '{data: crc_run[15:8], run_last: 1'b0, frame_end: 1'b0};
      n++;
      burst[n] = '{data: crc_run[7:0], run_last: 1'b0, frame_end: 1'b0};
      n++;
      pads = FRAME_BYTES - PAYLOAD_BYTES - 3;
      if (pads < 0) pads = 0;
      if (pads > MAX_RESULTS - n) pads = MAX_RESULTS - n;
      for (int i = 0; i < pads; i++) begin
        burst[n] = '{data: 8'h00, run_last: 1'b0, frame_end: 1'b0};
        n++;
      end
      burst[n-1].frame_end = 1'b1;
      crc_run = CRC_INIT;
      taken   = '0;
    end
    burst[n-1].run_last = 1'b1;
    for (int i = 0; i < n; i++) expected_words.push_back(burst[i]);
  endtask

  // Sample all ports at the rising edge, before the edge's updates land
  always @(posedge clk) begin
    frame_word_t got;
    frame_word_t want;
    if (rst) begin
      expected_words.delete();
      crc_run = CRC_INIT;
      taken   = '0;
      marker  = START_RESET;
    end else begin
      // a marker write takes effect for words accepted after this edge
      if (payload.valid && payload.ready) predict_frame_words(payload.payload_byte);
      if (cfg_wr_en) marker = cfg_wr_data;
      if (frame.valid && frame.ready) begin
        got = '{data: frame.out_byte, run_last: frame.run_last,
                frame_end: frame.frame_end};
        if (expected_words.size() == 0) begin
          errors++;
          $display("%0t: unexpected frame word: expected none, actual %02h/%0b/%0b",
                   $time, got.data, got.run_last, got.frame_end);
        end else begin
          want = expected_words.pop_front();
          if (got.data !== want.data || got.run_last !== want.run_last ||
              got.frame_end !== want.frame_end) begin
            errors++;
            $display("%0t: frame word mismatch (byte/run_last/frame_end): %s",
                     $time, "expected then actual");
            $display("  expected %02h/%0b/%0b, actual %02h/%0b/%0b",
                     want.data, want.run_last, want.frame_end,
                     got.data, got.run_last, got.frame_end);
          end
        end
      end
    end
    fail_count    <= errors;
    pending_words <= expected_words.size();
  end

endmodule

[tb/crc16_packet_framer_top_tb.sv]
`timescale 1ns / 1ps
// crc16_packet_framer_top_tb: drives payload words, start marker writes and frame
// back-pressure into the framer; checking is done by cpf_frame_checker.
// Depends on cpf_pkg, cpf_in_if, cpf_out_if, crc16_packet_framer_top, cpf_frame_checker.

module crc16_packet_framer_top_tb;

  localparam int LIMIT_CYCLES = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES  = 120;
  localparam int PHASE_WORDS  = 50;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;

  int fail_count;
  int pending_words;
  int cycle_count = 0;
  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int hold_epoch = 0;

  cpf_in_if  payload_ch ();
  cpf_out_if frame_ch ();

  crc16_packet_framer_top uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .payload     (payload_ch),
    .frame       (frame_ch)
  );

  cpf_frame_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .payload       (payload_ch),
    .frame         (frame_ch),
    .fail_count    (fail_count),
    .pending_words (pending_words)
  );

  always #2 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Frame sink: random stalls, plus a long hold each time hold_epoch moves
  initial begin
    int seen_epoch;
    int hold_left;
    seen_epoch = 0;
    hold_left  = 0;
    frame_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (seen_epoch != hold_epoch) begin
        seen_epoch = hold_epoch;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        frame_ch.ready <= 1'b0;
      end else begin
        frame_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
      end
    end
  end

  // Offer one payload word, with random idle cycles ahead of it
  task automatic send_payload_word(input logic [7:0] b);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      payload_ch.valid <= 1'b0;
      @(posedge clk);
    end
    payload_ch.valid        <= 1'b1;
    payload_ch.payload_byte <= b;
    @(posedge clk);
    while (!payload_ch.ready) @(posedge clk);
  endtask

  // Change the start marker once every frame word has drained
  task automatic write_start_marker(input logic [7:0] v);
    payload_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly uniform bytes, with the two extremes mixed in
  function automatic logic [7:0] rand_payload();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    logic [7:0] first_frame [21];
    first_frame = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h55, 8'hAA, 8'h0F,
                    8'hF0, 8'h33, 8'hCC, 8'h5A, 8'hA5, 8'h12, 8'h34, 8'h56, 8'h78,
                    8'h9A, 8'hBC, 8'hDE};
    rst                     <= 1'b1;
    cfg_wr_en               <= 1'b0;
    cfg_wr_data             <= 8'h00;
    payload_ch.valid        <= 1'b0;
    payload_ch.payload_byte <= 8'h00;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: one whole frame under the reset marker, then a new frame
    // start under the all-ones marker
    foreach (first_frame[i]) send_payload_word(first_frame[i]);
    write_start_marker(8'hFF);
    send_payload_word(8'hFF);
    send_payload_word(8'h00);

    // Random, sender idles less than receiver
    write_start_marker(8'h00);
    src_idle_pct = 28;
    snk_idle_pct = 47;
    repeat (PHASE_WORDS) send_payload_word(rand_payload());

    // Random, roles swapped
    write_start_marker(8'($urandom_range(0, 255)));
    src_idle_pct = 47;
    snk_idle_pct = 28;
    repeat (PHASE_WORDS) send_payload_word(rand_payload());

    // Random at full rate, with a long receiver hold part way in
    write_start_marker(8'($urandom_range(0, 255)));
    src_idle_pct = 0;
    snk_idle_pct = 0;
    for (int i = 0; i < PHASE_WORDS; i++) begin
      if (i == 10) hold_epoch++;
      send_payload_word(rand_payload());
    end
    payload_ch.valid <= 1'b0;

    // Drain and verdict
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_words == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
